@@ hdl/vnpu_pkg.sv @@
`default_nettype none
package vnpu_pkg;

  typedef logic [31:0] mag_t;

  localparam mag_t Q_ONE   = 32'h0001_0000;
  localparam mag_t SAT_POS = 32'h7FFF_FFFF;
  localparam mag_t SAT_NEG = 32'h8000_0000;

  // command codes; anything else is treated as length
  localparam logic [1:0] CMD_NORMALIZE = 2'd1;
  localparam logic [1:0] CMD_PERP      = 2'd2;

  // config register indexes
  localparam logic REG_LEN_SQ_FLOOR   = 1'b0;
  localparam logic REG_AXIS_NEAR_ZERO = 1'b1;

  localparam int QDIV_STEPS = 32;
  localparam int SQRT_STEPS = 32;
  localparam int LANE_STEPS = 17;

  // vector as magnitude/sign per component, index 0 is x
  typedef struct packed {
    logic             vec;
    mag_t [2:0]       m;
    logic [2:0]       n;
  } cvec_t;

  // length results traveling beside the lanes
  typedef struct packed {
    logic vec;
    logic deg;
    mag_t len;
    mag_t s_low;
  } nrm_t;

endpackage
`default_nettype wire

@@ hdl/vec3_normalize_perpendicular_unit_core.sv @@
// Throughput: one word per cycle while out_ready does not stall the output; perpendicular divide, square root and the
// per-component divides are fully pipelined, one bit per stage.
// The whole pipeline holds while a result waits on the output and out_ready is low.
// Reset clears all valid bits and restores length_sq_floor to 430, axis_near_zero to 16.
`default_nettype none
module vec3_normalize_perpendicular_unit_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [31:0]         magnitude,
  output logic                degenerate,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import vnpu_pkg::*;

  localparam int D = LANE_STEPS + 1;

  logic en;
  mag_t floor_sq;
  logic [15:0] thr;

  logic perp_valid, sq_valid;
  cvec_t perp_c, sq_c;
  nrm_t sq_n;
  logic signed [31:0] lane_o [0:2];

  logic [D-1:0] dv;
  nrm_t dn [0:D-1];

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_sq <= 32'd430;
      thr      <= 16'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEN_SQ_FLOOR:   floor_sq <= cfg_data;
        REG_AXIS_NEAR_ZERO: thr      <= cfg_data[15:0];
        default:            floor_sq <= floor_sq;
      endcase
    end
  end

  vnpu_perp u_perp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .thr       (thr),
    .out_valid (perp_valid),
    .out_c     (perp_c)
  );

  vnpu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (perp_valid),
    .in_c      (perp_c),
    .floor_sq  (floor_sq),
    .out_valid (sq_valid),
    .out_c     (sq_c),
    .out_n     (sq_n)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vnpu_lane u_lane (
      .clk (clk),
      .en  (en),
      .m   (sq_c.m[i]),
      .neg (sq_c.n[i]),
      .len (sq_n.len),
      .o   (lane_o[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      dv        <= {dv[D-2:0], sq_valid};
      out_valid <= dv[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0] <= sq_n;
      for (int k = 0; k < D - 1; k++) begin
        dn[k+1] <= dn[k];
      end
      // merge lanes; degenerate vectors map to (0, -1, 0)
      if (!dn[D-1].vec) begin
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
      end else if (dn[D-1].deg) begin
        out_x <= '0;
        out_y <= 32'(33'(0) - 33'(Q_ONE));
        out_z <= '0;
      end else begin
        out_x <= lane_o[0];
        out_y <= lane_o[1];
        out_z <= lane_o[2];
      end
      magnitude  <= dn[D-1].deg ? dn[D-1].s_low : dn[D-1].len;
      degenerate <= dn[D-1].deg;
    end
  end

endmodule
`default_nettype wire

@@ hdl/vnpu_perp.sv @@
`default_nettype none
module vnpu_perp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0]           cmd,
  input  logic signed [31:0]   vec_x,
  input  logic signed [31:0]   vec_y,
  input  logic signed [31:0]   vec_z,
  input  logic [15:0]          thr,
  output logic                 out_valid,
  output vnpu_pkg::cvec_t      out_c
);
  import vnpu_pkg::*;

  localparam int N = QDIV_STEPS;

  mag_t ax, ay, az;
  logic nx, ny, nz;
  logic signed [32:0] sum;
  logic [32:0] asum;
  logic sum_pos, qzero, qneg, ovf, use_q;
  cvec_t sel;

  logic [N:0] v_p, useq_p, qneg_p, qzero_p, ovf_p;
  cvec_t c_p [0:N];
  mag_t d_p [0:N];
  mag_t num_p [0:N];
  mag_t rem_p [0:N];
  mag_t quo_p [0:N];
  mag_t rem_nx [0:N-1];
  logic [N-1:0] ge_nx;
  mag_t qmag;
  cvec_t fin;

  assign ax = vec_x[31] ? mag_t'(0) - mag_t'(vec_x) : mag_t'(vec_x);
  assign ay = vec_y[31] ? mag_t'(0) - mag_t'(vec_y) : mag_t'(vec_y);
  assign az = vec_z[31] ? mag_t'(0) - mag_t'(vec_z) : mag_t'(vec_z);
  assign nx = ax < {16'b0, thr};
  assign ny = ay < {16'b0, thr};
  assign nz = az < {16'b0, thr};

  assign sum     = 33'(vec_x) + 33'(vec_y);
  assign asum    = sum[32] ? 33'(0) - 33'(sum) : 33'(sum);
  assign qzero   = (sum == 33'sd0);
  assign sum_pos = !sum[32] && !qzero;
  assign qneg    = sum_pos != vec_z[31];
  // quotient needs more than 32 bits (also covers a zero divisor)
  assign ovf     = {15'b0, asum[32:16]} >= az;

  always_comb begin
    sel      = '0;
    use_q    = 1'b0;
    sel.vec  = (cmd == CMD_NORMALIZE) || (cmd == CMD_PERP);
    sel.m[0] = ax;
    sel.m[1] = ay;
    sel.m[2] = az;
    sel.n    = {vec_z[31], vec_y[31], vec_x[31]};
    if (cmd == CMD_PERP) begin
      sel.n = '0;
      if (nx && ny) begin
        sel.m[0] = '0; sel.m[1] = Q_ONE; sel.m[2] = '0;
      end else if (nx) begin
        sel.m[0] = '0; sel.m[1] = az; sel.m[2] = ay;
        sel.n[1] = !vec_z[31]; sel.n[2] = vec_y[31];
      end else if (ny && nz) begin
        sel.m[0] = '0; sel.m[1] = Q_ONE; sel.m[2] = '0;
        sel.n[1] = 1'b1;
      end else if (ny) begin
        sel.m[0] = az; sel.m[1] = '0; sel.m[2] = ax;
        sel.n[0] = !vec_z[31]; sel.n[2] = vec_x[31];
      end else if (nz) begin
        sel.m[0] = ay; sel.m[1] = ax; sel.m[2] = '0;
        sel.n[0] = !vec_y[31]; sel.n[1] = vec_x[31];
      end else begin
        sel.m[0] = Q_ONE; sel.m[1] = Q_ONE; sel.m[2] = '0;
        use_q    = 1'b1;
      end
    end
  end

  // restoring divide, one quotient bit per stage
  always_comb begin
    logic [32:0] t;
    for (int k = 0; k < N; k++) begin
      t         = {rem_p[k], num_p[k][31]};
      ge_nx[k]  = t >= {1'b0, d_p[k]};
      rem_nx[k] = ge_nx[k] ? 32'(t - {1'b0, d_p[k]}) : t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_p       <= {v_p[N-1:0], in_valid};
      out_valid <= v_p[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_p[0]     <= sel;
      useq_p[0]  <= use_q;
      qneg_p[0]  <= qneg;
      qzero_p[0] <= qzero;
      ovf_p[0]   <= ovf;
      d_p[0]     <= az;
      num_p[0]   <= {asum[15:0], 16'b0};
      rem_p[0]   <= {15'b0, asum[32:16]};
      quo_p[0]   <= '0;
      for (int k = 0; k < N; k++) begin
        c_p[k+1]     <= c_p[k];
        useq_p[k+1]  <= useq_p[k];
        qneg_p[k+1]  <= qneg_p[k];
        qzero_p[k+1] <= qzero_p[k];
        ovf_p[k+1]   <= ovf_p[k];
        d_p[k+1]     <= d_p[k];
        num_p[k+1]   <= {num_p[k][30:0], 1'b0};
        rem_p[k+1]   <= rem_nx[k];
        quo_p[k+1]   <= {quo_p[k][30:0], ge_nx[k]};
      end
      out_c <= fin;
    end
  end

  always_comb begin
    if (qzero_p[N]) begin
      qmag = '0;
    end else if (ovf_p[N]) begin
      qmag = qneg_p[N] ? SAT_NEG : SAT_POS;
    end else if (qneg_p[N] && (quo_p[N] > SAT_NEG)) begin
      qmag = SAT_NEG;
    end else if (!qneg_p[N] && (quo_p[N] > SAT_POS)) begin
      qmag = SAT_POS;
    end else begin
      qmag = quo_p[N];
    end
    fin = c_p[N];
    if (useq_p[N]) begin
      fin.m[2] = qmag;
      fin.n[2] = qneg_p[N];
    end
  end

endmodule
`default_nettype wire

@@ hdl/vnpu_sqrt.sv @@
`default_nettype none
module vnpu_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vnpu_pkg::cvec_t   in_c,
  input  vnpu_pkg::mag_t    floor_sq,
  output logic              out_valid,
  output vnpu_pkg::cvec_t   out_c,
  output vnpu_pkg::nrm_t    out_n
);
  import vnpu_pkg::*;

  localparam int N = SQRT_STEPS;

  logic [1:0] v_h;
  cvec_t c1, c2;
  logic [63:0] sq [0:2];
  logic [63:0] p01, sq2;
  logic [63:0] s_sum;

  logic [N:0] v_p;
  cvec_t c_p [0:N];
  logic [N:0] deg_p;
  mag_t slo_p [0:N];
  logic [63:0] rn_p [0:N];
  logic [63:0] rr_p [0:N];
  logic [63:0] rn_nx [0:N-1];
  logic [63:0] rr_nx [0:N-1];

  assign s_sum = p01 + sq2;

  // bit-by-bit square root, one result bit per stage
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] tr;
    for (int k = 0; k < N; k++) begin
      bitv = 64'd1 << (62 - 2 * k);
      tr   = rr_p[k] + bitv;
      if (rn_p[k] >= tr) begin
        rn_nx[k] = rn_p[k] - tr;
        rr_nx[k] = (rr_p[k] >> 1) + bitv;
      end else begin
        rn_nx[k] = rn_p[k];
        rr_nx[k] = rr_p[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_h <= '0;
      v_p <= '0;
    end else if (en) begin
      v_h <= {v_h[0], in_valid};
      v_p <= {v_p[N-1:0], v_h[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 64'(in_c.m[i]) * 64'(in_c.m[i]);
      end
      c1       <= in_c;
      p01      <= sq[0] + sq[1];
      sq2      <= sq[2];
      c2       <= c1;
      c_p[0]   <= c2;
      deg_p[0] <= s_sum <= {32'b0, floor_sq};
      slo_p[0] <= s_sum[31:0];
      rn_p[0]  <= s_sum;
      rr_p[0]  <= '0;
      for (int k = 0; k < N; k++) begin
        c_p[k+1]   <= c_p[k];
        deg_p[k+1] <= deg_p[k];
        slo_p[k+1] <= slo_p[k];
        rn_p[k+1]  <= rn_nx[k];
        rr_p[k+1]  <= rr_nx[k];
      end
    end
  end

  assign out_valid   = v_p[N];
  assign out_c       = c_p[N];
  assign out_n.vec   = c_p[N].vec;
  assign out_n.deg   = deg_p[N];
  assign out_n.len   = rr_p[N][31:0];
  assign out_n.s_low = slo_p[N];

endmodule
`default_nettype wire

@@ hdl/vnpu_lane.sv @@
`default_nettype none
module vnpu_lane (
  input  logic                clk,
  input  logic                en,
  input  vnpu_pkg::mag_t      m,
  input  logic                neg,
  input  vnpu_pkg::mag_t      len,
  output logic signed [31:0]  o
);
  import vnpu_pkg::*;

  localparam int N = LANE_STEPS;

  // component magnitude never exceeds len, so the quotient fits in N bits
  logic first_ge;
  mag_t rem_p [0:N-1];
  mag_t d_p [0:N-1];
  logic [N-1:0] neg_p;
  logic [N-1:0] quo_p [0:N-1];
  mag_t rem_nx [0:N-2];
  logic [N-2:0] ge_nx;

  assign first_ge = m >= len;

  always_comb begin
    logic [32:0] t;
    for (int k = 0; k < N - 1; k++) begin
      t         = {rem_p[k], 1'b0};
      ge_nx[k]  = t >= {1'b0, d_p[k]};
      rem_nx[k] = ge_nx[k] ? 32'(t - {1'b0, d_p[k]}) : t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_p[0] <= first_ge ? m - len : m;
      d_p[0]   <= len;
      neg_p[0] <= neg;
      quo_p[0] <= {{(N-1){1'b0}}, first_ge};
      for (int k = 0; k < N - 1; k++) begin
        rem_p[k+1] <= rem_nx[k];
        d_p[k+1]   <= d_p[k];
        neg_p[k+1] <= neg_p[k];
        quo_p[k+1] <= {quo_p[k][N-2:0], ge_nx[k]};
      end
      o <= neg_p[N-1] ? 32'(33'(0) - 33'(quo_p[N-1])) : 32'(quo_p[N-1]);
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import vnpu_pkg::*;

  localparam logic [1:0] CMD_LENGTH = 2'd0;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [31:0] magnitude;
  logic degenerate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vec3_normalize_perpendicular_unit_core dut (.*);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0] mag;
    logic deg;
  } vres_t;

  vres_t unit_q[$];
  logic [31:0] floor_sq = 32'd430;
  logic [15:0] near_zero = 16'd16;
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic [63:0] m, input bit neg);
    if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic vres_t scale_unit(input logic signed [63:0] a, b, c);
    vres_t r;
    logic [63:0] s, l;
    logic signed [63:0] v[3];
    v[0] = a; v[1] = b; v[2] = c;
    s = 0;
    for (int i = 0; i < 3; i++) s += abs64(v[i]) * abs64(v[i]);
    if (s <= {32'd0, floor_sq}) begin
      r = '{x: 0, y: -32'sd65536, z: 0, mag: s[31:0], deg: 1'b1};
      return r;
    end
    l = root64(s);
    r.x = clamp32((abs64(v[0]) << 16) / l, v[0] < 0);
    r.y = clamp32((abs64(v[1]) << 16) / l, v[1] < 0);
    r.z = clamp32((abs64(v[2]) << 16) / l, v[2] < 0);
    r.mag = l[31:0];
    r.deg = 1'b0;
    return r;
  endfunction

  function automatic vres_t unit_predict(input logic [1:0] op,
                                         input logic signed [31:0] x32, y32, z32);
    vres_t r;
    logic signed [63:0] x, y, z, sum, q;
    logic [63:0] s, t;
    bit nx, ny, nz, neg;
    x = x32; y = y32; z = z32;
    if (op == CMD_NORMALIZE) return scale_unit(x, y, z);
    if (op == CMD_PERP) begin
      t = {48'd0, near_zero};
      nx = abs64(x) < t; ny = abs64(y) < t; nz = abs64(z) < t;
      if (nx && ny) return scale_unit(0, 65536, 0);
      if (nx) return scale_unit(0, -z, y);
      if (ny && nz) return scale_unit(0, -65536, 0);
      if (ny) return scale_unit(-z, 0, x);
      if (nz) return scale_unit(-y, x, 0);
      sum = x + y;
      neg = (sum > 0) != (z < 0);
      if (sum == 0) q = 0;
      else if (z == 0) q = clamp32(64'hFFFF_FFFF_FFFF, neg);
      else q = clamp32((abs64(sum) << 16) / abs64(z), neg);
      return scale_unit(65536, 65536, q);
    end
    s = abs64(x) * abs64(x) + abs64(y) * abs64(y) + abs64(z) * abs64(z);
    r.x = 0; r.y = 0; r.z = 0;
    if (s <= {32'd0, floor_sq}) begin
      r.mag = s[31:0]; r.deg = 1'b1;
    end else begin
      t = root64(s); r.mag = t[31:0]; r.deg = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return $signed($urandom_range(0, 40)) - 20;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      3: return $signed($urandom_range(0, 65536 * 4)) - 65536 * 2;
      default: return $signed($urandom() >> $urandom_range(0, 31));
    endcase
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LEN_SQ_FLOOR) floor_sq = val;
    else near_zero = val[15:0];
    @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] x, y, z);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op; vec_x <= x; vec_y <= y; vec_z <= z;
    do @(posedge clk); while (!in_ready);
    unit_q.push_back(unit_predict(op, x, y, z));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // directed rows: fixed expectation where obvious, otherwise predictor
  typedef struct {
    logic [1:0] op;
    logic signed [31:0] x, y, z;
    bit fixed;
    vres_t res;
  } row_t;

  row_t rows[] = '{
    '{CMD_LENGTH, 0, 0, 0, 1, '{0, 0, 0, 0, 1}},
    '{CMD_NORMALIZE, 0, 0, 0, 1, '{0, -32'sd65536, 0, 0, 1}},
    '{CMD_PERP, 0, 0, 0, 1, '{0, 32'sd65536, 0, 32'sd65536, 0}},
    '{CMD_LENGTH, 65536, 0, 0, 1, '{0, 0, 0, 32'd65536, 0}},
    '{CMD_NORMALIZE, 65536, 0, 0, 1, '{32'sd65536, 0, 0, 32'd65536, 0}},
    '{CMD_LENGTH, 20, 1, 3, 1, '{0, 0, 0, 32'd410, 1}},
    '{CMD_LENGTH, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, '{default: 0}},
    '{CMD_LENGTH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '{default: 0}},
    '{CMD_NORMALIZE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, '{default: 0}},
    '{CMD_NORMALIZE, 32'sh8000_0000, 0, 0, 0, '{default: 0}},
    '{CMD_NORMALIZE, 1, 0, 0, 0, '{default: 0}},
    '{CMD_PERP, 5, -3, 32'sh8000_0000, 0, '{default: 0}},
    '{CMD_PERP, 32'sh7FFF_FFFF, 32'sh8000_0000, 4, 0, '{default: 0}},
    '{CMD_PERP, 3, 65536, 32'sh8000_0000, 0, '{default: 0}},
    '{CMD_PERP, 32'sh8000_0000, 2, 3, 0, '{default: 0}},
    '{CMD_PERP, 32'sh8000_0000, 2, 65536, 0, '{default: 0}},
    '{CMD_PERP, 65536, 32'sh8000_0000, 1, 0, '{default: 0}},
    '{CMD_PERP, 65536, 65536, 65536, 0, '{default: 0}},
    '{CMD_PERP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16, 0, '{default: 0}},
    '{CMD_PERP, 16, -16, 16, 0, '{default: 0}},
    '{CMD_SPARE, 65536, 0, 0, 1, '{0, 0, 0, 32'd65536, 0}}
  };

  initial begin
    int n;
    logic [1:0] op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_word(rows[i].op, rows[i].x, rows[i].y, rows[i].z);
      if (rows[i].fixed) unit_q[$] = rows[i].res;
    end
    settle();
    // zero near-zero threshold: divide by zero z and zero sum
    write_reg(REG_AXIS_NEAR_ZERO, 16'd0);
    write_reg(REG_LEN_SQ_FLOOR, 32'd0);
    send_word(CMD_PERP, 65536, 65536, 0);
    send_word(CMD_PERP, -65536, -3, 0);
    send_word(CMD_PERP, 65536, -65536, 0);
    send_word(CMD_LENGTH, 0, 0, 0);
    send_word(CMD_PERP, 1, 0, 0);
    settle();
    write_reg(REG_LEN_SQ_FLOOR, 32'hFFFF_FFFF);
    write_reg(REG_AXIS_NEAR_ZERO, 16'hFFFF);
    for (int p = 0; p < 4; p++) begin
      if (p == 1) begin
        write_reg(REG_LEN_SQ_FLOOR, $urandom());
        write_reg(REG_AXIS_NEAR_ZERO, $urandom_range(0, 65535));
      end else if (p == 2) begin
        write_reg(REG_LEN_SQ_FLOOR, 32'd430);
        write_reg(REG_AXIS_NEAR_ZERO, 16'd16);
      end else if (p == 3) begin
        write_reg(REG_LEN_SQ_FLOOR, $urandom_range(0, 1 << 20));
        write_reg(REG_AXIS_NEAR_ZERO, $urandom_range(0, 300));
      end
      n = 375;
      for (int k = 0; k < n; k++) begin
        calm = (p == 2) && (k < 150);
        op = $urandom_range(0, 15) == 0 ? CMD_SPARE : 2'($urandom_range(0, 2));
        send_word(op, rand_comp(), rand_comp(), rand_comp());
      end
      calm = 1'b0;
      settle();
    end
    stim_done = 1'b1;
  end

  // receive side
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm || $urandom_range(0, 99) >= 32;
  end

  always @(posedge clk) begin
    vres_t want;
    if (!rst && out_valid && out_ready) begin
      if (unit_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %h %h %h %h %b",
                                   out_x, out_y, out_z, magnitude, degenerate);
      end else begin
        want = unit_q.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
            magnitude !== want.mag || degenerate !== want.deg) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                     want.x, want.y, want.z, want.mag, want.deg,
                     out_x, out_y, out_z, magnitude, degenerate);
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (stim_done) begin
      if (errors == 0 && unit_q.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
